/* hdl/sorted_record_table_macros.svh */
// assertion macros used by the checker of the sorted record table
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

// same-cycle implication under an active-low reset
`define SRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted record table: implication check failed");

// next-cycle implication under an active-low reset
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted record table: next-cycle check failed");

`endif

/* hdl/srt_pkg.sv */
// types, constants and helper functions of the sorted record table
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NAME_BYTES  = 25;
    localparam int NAME_WORDS  = 4;
    localparam int WORD_W      = 56;
    localparam int KEY_W       = 32;
    localparam int NAME_W      = NAME_WORDS * WORD_W;
    localparam int NAME_SLOTS  = NAME_W / 8;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    // request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // response status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] qty;
        logic [NAME_W-1:0]       name;
    } record_t;

    typedef struct packed {
        logic [1:0] op;
        record_t    rec;
    } req_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                    ins_en;
        logic                    upd_en;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] qty;
        record_t                 new_rec;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] found_number;
        logic signed [KEY_W-1:0] found_quantity;
        logic [NAME_W-1:0]       name;
    } result_t;

    // zero every name byte from the first zero byte or the length limit on
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] clean;
        logic              ended;
        clean = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_SLOTS; b++) begin
            if (b >= NAME_BYTES || raw[b*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                clean[b*8 +: 8] = raw[b*8 +: 8];
            end
        end
        return clean;
    endfunction

endpackage

/* hdl/srt_req_if.sv */
// request channel of the sorted record table
interface srt_req_if;
    import srt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic signed [KEY_W-1:0] part_number;
    logic signed [KEY_W-1:0] new_quantity;
    logic [WORD_W-1:0]       name_word0;
    logic [WORD_W-1:0]       name_word1;
    logic [WORD_W-1:0]       name_word2;
    logic [WORD_W-1:0]       name_word3;

    modport source (
        output valid, op, part_number, new_quantity,
               name_word0, name_word1, name_word2, name_word3,
        input  ready
    );

    modport sink (
        input  valid, op, part_number, new_quantity,
               name_word0, name_word1, name_word2, name_word3,
        output ready
    );
endinterface

/* hdl/srt_rsp_if.sv */
// response channel of the sorted record table
interface srt_rsp_if;
    import srt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] found_number;
    logic signed [KEY_W-1:0] found_quantity;
    logic [WORD_W-1:0]       out_name0;
    logic [WORD_W-1:0]       out_name1;
    logic [WORD_W-1:0]       out_name2;
    logic [WORD_W-1:0]       out_name3;

    modport source (
        output valid, status, found_number, found_quantity,
               out_name0, out_name1, out_name2, out_name3,
        input  ready
    );

    modport sink (
        input  valid, status, found_number, found_quantity,
               out_name0, out_name1, out_name2, out_name3,
        output ready
    );
endinterface

/* hdl/srt_cell.sv */
// one record slot of the sorted row: compare, shift right on insert, quantity update
module srt_cell import srt_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      occupied,
    input  logic      left_take,
    input  logic      left_hit,
    input  record_t   left_rec,
    output record_t   rec,
    output logic      take,
    output logic      hit,
    output logic      first,
    output record_t   sel_rec
);

    record_t rec_reg;
    record_t rec_next;

    // slot at or after the insert point: free, or key not below the new one
    assign take  = !occupied || (rec_reg.key >= cmd.key);
    assign hit   = occupied && (rec_reg.key == cmd.key);
    // keys are sorted, so matches are contiguous and the first has no matching left
    assign first = hit && !left_hit;

    assign rec     = rec_reg;
    assign sel_rec = first ? rec_reg : '0;

    // next slot contents
    always_comb
    begin
        rec_next = rec_reg;
        if (cmd.ins_en) begin
            if (left_take) begin
                rec_next = left_rec;
            end
            else if (take) begin
                rec_next = cmd.new_rec;
            end
        end
        else if (cmd.upd_en && first) begin
            rec_next.qty = cmd.qty;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

/* hdl/sorted_record_table.sv */
// sorted record table: a row of compare-and-shift cells kept in ascending key order
// the request register feeds the cell row; the match is gathered by a two-level
//   OR tree whose first level is registered per group of cells; no new request
//   is taken while the cell row acts or while a stalled response holds the tree
// reset clears the fill count and the pipeline valids; slots hold no reset value
module sorted_record_table import srt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    srt_req_if.sink   req,
    srt_rsp_if.source rsp
);

    logic             exec_v_reg;
    logic             exec_v_next;
    logic             red_v_reg;
    logic             red_v_next;
    logic             out_v_reg;
    logic             out_v_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_t             req_reg;
    logic [1:0]       red_op_reg;
    logic             red_full_reg;
    result_t          out_reg;
    result_t          out_next;

    record_t          grp_rec_reg [NUM_GROUPS];
    logic             grp_hit_reg [NUM_GROUPS];
    record_t          grp_rec_or  [NUM_GROUPS];
    logic             grp_hit_or  [NUM_GROUPS];

    record_t          cell_rec   [TABLE_DEPTH];
    record_t          cell_sel   [TABLE_DEPTH];
    logic             cell_take  [TABLE_DEPTH];
    logic             cell_hit   [TABLE_DEPTH];
    logic             cell_first [TABLE_DEPTH];

    cell_cmd_t        cmd;
    logic             full;
    logic             red_move;
    logic             in_ready;
    logic             accept;
    req_t             req_in;

    // handshake
    assign red_move  = !out_v_reg || rsp.ready;
    assign in_ready  = !exec_v_reg && (!red_v_reg || red_move);
    assign accept    = req.valid && in_ready;
    assign req.ready = in_ready;

    // incoming request with its name cleaned
    always_comb
    begin
        req_in.op       = req.op;
        req_in.rec.key  = req.part_number;
        req_in.rec.qty  = req.new_quantity;
        req_in.rec.name = clean_name({req.name_word3, req.name_word2,
                                      req.name_word1, req.name_word0});
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            req_reg <= req_in;
        end
    end

    // command to the cell row
    assign full = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        cmd.ins_en  = exec_v_reg && (req_reg.op == OP_INSERT) && !full;
        cmd.upd_en  = exec_v_reg && (req_reg.op == OP_UPDATE);
        cmd.key     = req_reg.rec.key;
        cmd.qty     = req_reg.rec.qty;
        cmd.new_rec = req_reg.rec;
    end

    // row of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic    occupied;
        logic    left_take;
        logic    left_hit;
        record_t left_rec;

        assign occupied = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_head
            assign left_take = 1'b0;
            assign left_hit  = 1'b0;
            assign left_rec  = '0;
        end
        else begin : g_body
            assign left_take = cell_take[i-1];
            assign left_hit  = cell_hit[i-1];
            assign left_rec  = cell_rec[i-1];
        end

        srt_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (occupied),
            .left_take (left_take),
            .left_hit  (left_hit),
            .left_rec  (left_rec),
            .rec       (cell_rec[i]),
            .take      (cell_take[i]),
            .hit       (cell_hit[i]),
            .first     (cell_first[i]),
            .sel_rec   (cell_sel[i])
        );
    end

    // first level of the match tree, one register per group of cells
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        always_comb
        begin
            grp_rec_or[g] = '0;
            grp_hit_or[g] = 1'b0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < TABLE_DEPTH) begin
                    grp_rec_or[g] = grp_rec_or[g] | cell_sel[g * GROUP_SIZE + k];
                    grp_hit_or[g] = grp_hit_or[g] | cell_first[g * GROUP_SIZE + k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (exec_v_reg) begin
                grp_rec_reg[g] <= grp_rec_or[g];
                grp_hit_reg[g] <= grp_hit_or[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_v_reg) begin
            red_op_reg   <= req_reg.op;
            red_full_reg <= full;
        end
    end

    // second level of the tree and the response
    always_comb
    begin
        record_t found_rec;
        logic    found;
        found_rec = '0;
        found     = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            found_rec = found_rec | grp_rec_reg[g];
            found     = found | grp_hit_reg[g];
        end

        out_next = '0;
        unique case (red_op_reg)
            OP_INSERT:
            begin
                if (red_full_reg) begin
                    out_next.status = STATUS_FULL;
                end
                else begin
                    out_next.status         = STATUS_DONE;
                    out_next.found_number   = req_reg.rec.key;
                    out_next.found_quantity = req_reg.rec.qty;
                    out_next.name           = req_reg.rec.name;
                end
            end
            OP_SEARCH, OP_UPDATE:
            begin
                if (found) begin
                    out_next.status         = STATUS_DONE;
                    out_next.found_number   = found_rec.key;
                    out_next.found_quantity = (red_op_reg == OP_UPDATE) ?
                                              req_reg.rec.qty : found_rec.qty;
                    out_next.name           = found_rec.name;
                end
                else begin
                    out_next.status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                out_next.status = STATUS_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (red_v_reg && red_move) begin
            out_reg <= out_next;
        end
    end

    // control state
    always_comb
    begin
        exec_v_next = accept;
        red_v_next  = exec_v_reg ? 1'b1 : (red_move ? 1'b0 : red_v_reg);
        if (red_v_reg && red_move) begin
            out_v_next = 1'b1;
        end
        else if (rsp.ready) begin
            out_v_next = 1'b0;
        end
        else begin
            out_v_next = out_v_reg;
        end
        count_next = cmd.ins_en ? count_reg + CNT_W'(1) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            exec_v_reg <= 1'b0;
            red_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else begin
            exec_v_reg <= exec_v_next;
            red_v_reg  <= red_v_next;
            out_v_reg  <= out_v_next;
            count_reg  <= count_next;
        end
    end

    // response port
    assign rsp.valid          = out_v_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.found_number   = out_reg.found_number;
    assign rsp.found_quantity = out_reg.found_quantity;
    assign rsp.out_name0      = out_reg.name[0*WORD_W +: WORD_W];
    assign rsp.out_name1      = out_reg.name[1*WORD_W +: WORD_W];
    assign rsp.out_name2      = out_reg.name[2*WORD_W +: WORD_W];
    assign rsp.out_name3      = out_reg.name[3*WORD_W +: WORD_W];

endmodule

/* hdl/srt_checker.sv */
// port-level checks of the sorted record table and their binding
`include "sorted_record_table_macros.svh"

module srt_checker import srt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [1:0]              rsp_status,
    input logic signed [KEY_W-1:0] rsp_found_number,
    input logic signed [KEY_W-1:0] rsp_found_quantity
);

    // the cell row is busy the cycle after a request
    `SRT_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, req_valid && req_ready, !req_ready)

    // a miss or a full table carries no record
    `SRT_ASSERT_IMPL(a_miss_is_zero, clk, rst_n, rsp_valid && (rsp_status != STATUS_DONE), (rsp_found_number == 0) && (rsp_found_quantity == 0))

    // a fresh response is traced back to an accepted request
    `SRT_ASSERT_IMPL(a_rsp_latency, clk, rst_n, $rose(rsp_valid), $past(req_valid && req_ready, 3))

    // a stalled response holds
    `SRT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

endmodule

bind sorted_record_table srt_checker u_srt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_found_number   (rsp.found_number),
    .rsp_found_quantity (rsp.found_quantity)
);
